// File: sv/pwrl_pkg.sv
// Shared types and constants of the per-peer window rate limiter.
`default_nettype none

package pwrl_pkg;

    // Table size and count width
    localparam int PEER_COUNT  = 64;
    localparam int COUNT_BITS  = 16;
    localparam int PEER_AW     = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;

    // Field widths of the item
    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 6;
    localparam int LIMIT_W     = 16;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 3;

    // Width wide enough to compare count+1 with the limit without wrapping
    localparam int CMP_W       = 33;
    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

    // Window register value after reset
    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000000;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CHECK  = 2'd0,
        ACT_SET    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_RSVD   = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED = 3'd0,
        STAT_OVER    = 3'd1,
        STAT_BUSY    = 3'd2,
        STAT_UNKNOWN = 3'd3,
        STAT_UPDATED = 3'd4
    } status_t;

    // One peer table entry as held in the table memory
    typedef struct packed {
        logic [LIMIT_W-1:0]    limit;
        logic [COUNT_BITS-1:0] count;
        logic                  busy;
        logic [TIME_W-1:0]     stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: sv/pwrl_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module pwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/per_peer_window_rate_limiter.sv
// Top level of the per-peer fixed-window rate limiter.
//
// Each item (check, set or delete of one peer) gives exactly one result item.
// The peer table memory is read in the cycle in which an item is accepted, and
// its data returns in the next cycle, where the execute state makes the decision
// and, for a set or a check of a valid peer, writes the entry back once the
// output register is free; the result is registered into the output register
// when the item completes. The block handles one item at a time and accepts no
// new item until the last has completed; a stalled result holds the block in its
// execute state until the output register frees. Valid marks live in flip-flops
// cleared by reset, so no clearing pass is needed and items are accepted straight after reset.
// window_ticks may only be written while the block is idle.
`default_nettype none

module per_peer_window_rate_limiter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         window_ticks_we,
    input  wire logic [pwrl_pkg::TIME_W-1:0]  window_ticks,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [pwrl_pkg::ACTION_W-1:0] action,
    input  wire logic [pwrl_pkg::INDEX_W-1:0] peer_index,
    input  wire logic [pwrl_pkg::LIMIT_W-1:0] limit_value,
    input  wire logic [pwrl_pkg::TIME_W-1:0]  now_time,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              granted,
    output logic [pwrl_pkg::STATUS_W-1:0]     status
);

    import pwrl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [TIME_W-1:0]      window_reg;
    logic [PEER_COUNT-1:0]  valid_reg, valid_next;

    action_t                action_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [TIME_W-1:0]      now_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   granted_reg, granted_next;
    status_t                status_reg, status_next;

    logic                   in_accept;
    logic                   out_free;
    logic                   exec_fire;
    logic                   in_range;
    logic [PEER_AW-1:0]     addr;
    logic                   hit;

    logic [ENTRY_W-1:0]     rd_bits;
    entry_t                 rd_entry;
    entry_t                 wr_entry;
    logic                   wr_en;

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    // Peer table: read at acceptance, written back when a set or a check of a valid peer completes
    pwrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PEER_COUNT),
        .AW    (PEER_AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_entry),
        .rd_en   (in_accept),
        .rd_addr (PEER_AW'(peer_index)),
        .rd_data (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);
    assign in_range = (32'(idx_reg) < PEER_COUNT);
    assign addr     = PEER_AW'(idx_reg);
    assign hit      = in_range && valid_reg[addr];

    // Decision and entry update
    always_comb
    begin
        logic [TIME_W-1:0]     elapsed;
        logic [COUNT_BITS-1:0] cur_count;
        logic                  cur_busy;
        logic [CMP_W-1:0]      lim_eff;
        logic [CMP_W-1:0]      count_inc;

        elapsed   = now_reg - rd_entry.stamp;
        cur_count = rd_entry.count;
        cur_busy  = rd_entry.busy;
        if (elapsed > window_reg)
        begin
            cur_count = '0;
            cur_busy  = 1'b0;
        end
        lim_eff   = (CMP_W'(rd_entry.limit) > COUNT_MAX) ? COUNT_MAX
                                                          : CMP_W'(rd_entry.limit);
        count_inc = CMP_W'(cur_count) + CMP_W'(1);

        wr_entry     = rd_entry;
        wr_en        = 1'b0;
        valid_next   = valid_reg;
        status_next  = STAT_UNKNOWN;

        case (action_reg)
            ACT_CHECK:
            begin
                if (hit)
                begin
                    wr_en          = exec_fire;
                    wr_entry.count = cur_count;
                    wr_entry.busy  = cur_busy;
                    if (cur_busy)
                    begin
                        status_next = STAT_BUSY;
                    end
                    else if (count_inc <= lim_eff)
                    begin
                        wr_entry.count = COUNT_BITS'(count_inc);
                        wr_entry.stamp = now_reg;
                        status_next    = STAT_GRANTED;
                    end
                    else
                    begin
                        wr_entry.busy  = 1'b1;
                        wr_entry.stamp = now_reg;
                        status_next    = STAT_OVER;
                    end
                end
            end
            ACT_SET:
            begin
                if (in_range)
                begin
                    wr_en           = exec_fire;
                    wr_entry.limit  = limit_reg;
                    wr_entry.count  = '0;
                    wr_entry.busy   = 1'b0;
                    wr_entry.stamp  = now_reg;
                    valid_next[addr] = 1'b1;
                    status_next     = STAT_UPDATED;
                end
            end
            ACT_DELETE:
            begin
                if (in_range)
                begin
                    valid_next[addr] = 1'b0;
                    status_next      = STAT_UPDATED;
                end
            end
            default:
            begin
                status_next = STAT_UNKNOWN;
            end
        endcase

        granted_next = (status_next == STAT_GRANTED);
    end

    // Sequencer and output register control
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            window_reg    <= WINDOW_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                valid_reg <= valid_next;
            end
            if (window_ticks_we)
            begin
                window_reg <= window_ticks;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action_t'(action);
            idx_reg    <= peer_index;
            limit_reg  <= limit_value;
            now_reg    <= now_time;
        end
        if (exec_fire)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign granted = granted_reg;
    assign status  = status_reg;

`ifndef SYNTHESIS
    // Granted flag agrees with the status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted == (status == STAT_GRANTED)))
        else $error("granted disagrees with status");

    // An accepted item holds off the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input not stalled while an item is in progress");

    // Completing an item always presents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid)
        else $error("completed item gave no result");

    // A set of an in-range peer leaves its valid mark on
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && action_reg == ACT_SET && in_range) |=> valid_reg[$past(addr)])
        else $error("set action did not mark the peer valid");

    // Table is written only when an item completes
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> exec_fire)
        else $error("table written outside item completion");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench of the per-peer window rate limiter, with its own peer table predictor.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pwrl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // One pending input item
    typedef struct packed {
        action_t            act;
        logic [INDEX_W-1:0] peer;
        logic [LIMIT_W-1:0] lim;
        logic [TIME_W-1:0]  now;
    } peer_request_t;

    // One awaited result item
    typedef struct packed {
        logic    granted;
        status_t status;
    } verdict_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                window_ticks_we = 1'b0;
    logic [TIME_W-1:0]   window_ticks = WINDOW_RESET;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic [INDEX_W-1:0]  peer_index = '0;
    logic [LIMIT_W-1:0]  limit_value = '0;
    logic [TIME_W-1:0]   now_time = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                granted;
    logic [STATUS_W-1:0] status;

    peer_request_t pending_requests[$];
    verdict_t      awaited_verdicts[$];
    peer_request_t next_request;
    verdict_t      head_verdict;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    logic [TIME_W-1:0] tick_now = '0;

    // Predictor copy of the peer table and the window register
    logic [TIME_W-1:0]     window_copy = WINDOW_RESET;
    logic                  peer_valid [PEER_COUNT];
    logic [LIMIT_W-1:0]    peer_limit [PEER_COUNT];
    logic [COUNT_BITS-1:0] peer_count [PEER_COUNT];
    logic                  peer_busy  [PEER_COUNT];
    logic [TIME_W-1:0]     peer_stamp [PEER_COUNT];

    per_peer_window_rate_limiter u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .window_ticks_we (window_ticks_we),
        .window_ticks    (window_ticks),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .peer_index      (peer_index),
        .limit_value     (limit_value),
        .now_time        (now_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted         (granted),
        .status          (status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Admission decision for one item; updates the predictor's table
    function automatic status_t admit_request(action_t act, logic [INDEX_W-1:0] idx,
                                              logic [LIMIT_W-1:0] lim,
                                              logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic [CMP_W-1:0]  eff_limit;
        status_t           st;
        st = STAT_UNKNOWN;
        if (int'(idx) < PEER_COUNT)
        begin
            case (act)
                ACT_CHECK:
                    if (peer_valid[idx])
                    begin
                        elapsed = now - peer_stamp[idx];
                        // idle gap past the window starts a fresh window
                        if (elapsed > window_copy)
                        begin
                            peer_busy[idx]  = 1'b0;
                            peer_count[idx] = '0;
                        end
                        if (peer_busy[idx])
                            st = STAT_BUSY;
                        else
                        begin
                            eff_limit = (CMP_W'(peer_limit[idx]) > COUNT_MAX) ?
                                        COUNT_MAX : CMP_W'(peer_limit[idx]);
                            if (CMP_W'(peer_count[idx]) + CMP_W'(1) <= eff_limit)
                            begin
                                peer_count[idx] = peer_count[idx] + 1'b1;
                                peer_stamp[idx] = now;
                                st = STAT_GRANTED;
                            end
                            else
                            begin
                                peer_busy[idx]  = 1'b1;
                                peer_stamp[idx] = now;
                                st = STAT_OVER;
                            end
                        end
                    end
                ACT_SET:
                begin
                    peer_valid[idx] = 1'b1;
                    peer_limit[idx] = lim;
                    peer_count[idx] = '0;
                    peer_busy[idx]  = 1'b0;
                    peer_stamp[idx] = now;
                    st = STAT_UPDATED;
                end
                ACT_DELETE:
                begin
                    peer_valid[idx] = 1'b0;
                    st = STAT_UPDATED;
                end
                default: ;
            endcase
        end
        return st;
    endfunction

    // Driver: presents queued items, predicts each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                head_verdict.status = admit_request(action_t'(action), peer_index,
                                                    limit_value, now_time);
                head_verdict.granted = (head_verdict.status == STAT_GRANTED);
                awaited_verdicts.push_back(head_verdict);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_request = pending_requests.pop_front();
                    in_valid    <= 1'b1;
                    action      <= next_request.act;
                    peer_index  <= next_request.peer;
                    limit_value <= next_request.lim;
                    now_time    <= next_request.now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest awaited one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_verdicts.size() == 0)
                    report_mismatch($sformatf("result with none awaited: granted %0d status %0d",
                                              granted, status));
                else
                begin
                    head_verdict = awaited_verdicts.pop_front();
                    if (granted !== head_verdict.granted)
                        report_mismatch($sformatf("granted: expected %0d, got %0d",
                                                  head_verdict.granted, granted));
                    if (status !== head_verdict.status)
                        report_mismatch($sformatf("status: expected %0d, got %0d",
                                                  head_verdict.status, status));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic add_request(action_t act, int unsigned peer, int unsigned lim,
                               logic [TIME_W-1:0] now);
        peer_request_t req;
        req.act  = act;
        req.peer = INDEX_W'(peer);
        req.lim  = LIMIT_W'(lim);
        req.now  = now;
        pending_requests.push_back(req);
    endtask

    // Random traffic: mostly a handful of peers, small limits, advancing time
    task automatic add_random_requests(int n, int unsigned step_max);
        peer_request_t req;
        int unsigned   pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                req.act = ACT_CHECK;
            else if (pick < 84)
                req.act = ACT_SET;
            else if (pick < 95)
                req.act = ACT_DELETE;
            else
                req.act = ACT_RSVD;
            if ($urandom_range(0, 3) == 0)
                req.peer = INDEX_W'($urandom);
            else
                req.peer = INDEX_W'($urandom_range(0, 5));
            if ($urandom_range(0, 7) == 0)
                req.lim = LIMIT_W'($urandom);
            else
                req.lim = LIMIT_W'($urandom_range(0, 4));
            // occasional jump anywhere on the time line, wrap included
            if ($urandom_range(0, 19) == 0)
                tick_now = $urandom;
            else
                tick_now = tick_now + $urandom_range(0, step_max);
            req.now = tick_now;
            pending_requests.push_back(req);
        end
    endtask

    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || in_valid || awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Window register is written only with nothing in flight
    task automatic write_window(logic [TIME_W-1:0] value);
        wait_until_idle();
        window_ticks_we <= 1'b1;
        window_ticks    <= value;
        window_copy      = value;
        @(posedge clk);
        window_ticks_we <= 1'b0;
        @(posedge clk);
    endtask

    // Timeout
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        for (int i = 0; i < PEER_COUNT; i++)
            peer_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 46;
        write_window(32'd10);

        // unknown peer, reserved action, delete of an absent peer
        add_request(ACT_CHECK,  0, 16'hFFFF, 32'd50);
        add_request(ACT_RSVD,   5, 3, 32'd60);
        add_request(ACT_DELETE, 7, 0, 32'd70);
        // grant up to the limit, then over limit and still busy
        add_request(ACT_SET,   0, 2, 32'd100);
        add_request(ACT_CHECK, 0, 0, 32'd101);
        add_request(ACT_CHECK, 0, 0, 32'd102);
        add_request(ACT_CHECK, 0, 0, 32'd103);
        add_request(ACT_CHECK, 0, 0, 32'd110);
        add_request(ACT_CHECK, 0, 0, 32'd113);
        // one tick past the window clears busy
        add_request(ACT_CHECK, 0, 0, 32'd114);
        // zero limit at the top entry, across the time wrap
        add_request(ACT_SET,   63, 0, 32'hFFFF_FFF0);
        add_request(ACT_CHECK, 63, 0, 32'hFFFF_FFF5);
        add_request(ACT_CHECK, 63, 0, 32'h0000_0003);
        // largest limit, elapsed time wrapping both ways
        add_request(ACT_SET,   63, 16'hFFFF, 32'hFFFF_FFFE);
        add_request(ACT_CHECK, 63, 16'hFFFF, 32'h0000_0002);
        add_request(ACT_CHECK, 63, 0, 32'hFFFF_FFFF);
        // delete then check of the same peer
        add_request(ACT_DELETE, 0, 16'hFFFF, 32'hFFFF_FFFF);
        add_request(ACT_CHECK,  0, 0, 32'd200);
        add_request(ACT_DELETE, 0, 0, 32'd201);
        add_request(ACT_RSVD,  63, 16'hFFFF, 32'hFFFF_FFFF);
        add_request(ACT_CHECK, 63, 16'hFFFF, 32'h0000_0000);
        add_random_requests(60, 6);

        // zero window: any change of time starts a fresh window
        write_window(32'd0);
        add_random_requests(70, 1);

        send_idle_pct = 46;
        recv_idle_pct = 23;
        write_window(32'd1);
        add_random_requests(80, 2);

        write_window(32'hFFFF_FFFF);
        add_random_requests(70, 1000);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_window(WINDOW_RESET);
        add_random_requests(90, 400000);

        write_window(32'd20);
        add_random_requests(80, 8);

        wait_until_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
